/* design/lav_pkg.sv */
`default_nettype none
// ============================================================================
// lav_pkg: shared types and constants for the look-at view matrix block
// Fixed-point format, item and result structs, register indexes.
// ============================================================================
package lav_pkg;

  // Fixed-point format of all vector values
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  // Normalized basis component: magnitude at most a little over one
  localparam int BAS_W  = FRAC_BITS + 4;
  // Product of a 32-bit word and a basis component
  localparam int PROD_W = 32 + BAS_W;
  // Dividend width of the normalizer: 31-bit magnitude, fraction, round carry
  localparam int NUM_W  = 32 + FRAC_BITS;

  typedef logic signed [31:0]      word_t;
  typedef logic signed [BAS_W-1:0] basis_t;
  typedef logic signed [63:0]      wide_t;

  // One accepted command beat
  typedef struct packed {
    word_t [2:0] eye;
    word_t [2:0] dir;
  } item_t;

  // Normalizer status
  typedef struct packed {
    logic done;
    logic zero;
  } norm_sts_t;

  // One result beat
  typedef struct packed {
    logic [1:0] row_index;
    word_t      col0;
    word_t      col1;
    word_t      col2;
    word_t      col3;
    logic       last_row;
    logic       degenerate;
  } res_t;

  // Register indexes
  localparam logic [1:0] CFG_UP_X = 2'd0;
  localparam logic [1:0] CFG_UP_Y = 2'd1;
  localparam logic [1:0] CFG_UP_Z = 2'd2;

  localparam word_t UP_X_RESET = 32'sd0;
  localparam word_t UP_Y_RESET = 32'sd65536;
  localparam word_t UP_Z_RESET = 32'sd0;

  // Fixed-point one
  localparam word_t ONE = word_t'(64'sd1 <<< FRAC_BITS);

endpackage
`default_nettype wire

/* design/lav_front.sv */
`default_nettype none
// ============================================================================
// lav_front: command intake
// Takes command beats into a two-entry queue that feeds the back end.
// ============================================================================
module lav_front import lav_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire item_t item_i,
  output logic       busy_o,
  input  wire logic  pop_i,
  output logic       avail_o,
  output item_t      item_o
);

  item_t [1:0] mem_q;
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push;

  // Queue full holds off new commands
  assign busy_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign push    = start_i && !busy_o;
  assign item_o  = mem_q[rd_ptr_q];

  // Storage, written in the clocked block
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* design/lav_norm.sv */
`default_nettype none
// ============================================================================
// lav_norm: serial vector normalizer
// Scales a 3-vector to unit length: prescale shift, sum of squares,
// bit-pair square root and restoring division, one step per cycle.
// ============================================================================
module lav_norm import lav_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire wide_t [2:0] vec_i,
  output norm_sts_t        sts_o,
  output basis_t [2:0]     vec_o
);

  localparam int DCNT_W = $clog2(NUM_W);

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DLOAD, N_DIV
  } state_e;

  state_e              state_q;
  logic [2:0][63:0]    mag_q;
  logic [2:0]          neg_q;
  logic [1:0]          idx_q;
  logic [63:0]         sum_q;
  logic [63:0]         rn_q;
  logic [63:0]         res_q;
  logic [63:0]         bit_q;
  logic [31:0]         len_q;
  logic [NUM_W-1:0]    num_q;
  logic [31:0]         rem_q;
  logic [NUM_W-1:0]    quo_q;
  logic [DCNT_W-1:0]   dcnt_q;
  basis_t [2:0]        out_q;
  norm_sts_t           sts_q;

  logic [2:0][63:0]    mag_in;
  logic [63:0]         orv;
  logic [61:0]         sq;
  logic [64:0]         trial;
  logic                take;
  logic [32:0]         rem_sh;
  logic                dtake;
  logic [31:0]         rem_nx;
  logic [NUM_W-1:0]    quo_nx;
  logic [BAS_W-1:0]    qmag;
  logic [BAS_W-1:0]    qval;

  assign sts_o = sts_q;
  assign vec_o = out_q;

  // Magnitudes of the incoming vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vec_i[i][63] ? (~vec_i[i] + 64'd1) : vec_i[i];
    end
  end

  // Datapath of the iterative steps
  always_comb begin
    orv    = mag_q[0] | mag_q[1] | mag_q[2];
    sq     = mag_q[idx_q][30:0] * mag_q[idx_q][30:0];
    trial  = {1'b0, res_q} + {1'b0, bit_q};
    take   = ({1'b0, rn_q} >= trial);
    rem_sh = {rem_q, num_q[NUM_W-1]};
    dtake  = (rem_sh >= {1'b0, len_q});
    rem_nx = dtake ? 32'(rem_sh - {1'b0, len_q}) : rem_sh[31:0];
    quo_nx = {quo_q[NUM_W-2:0], dtake};
    qmag   = quo_nx[BAS_W-1:0];
    qval   = neg_q[idx_q] ? (~qmag + BAS_W'(1)) : qmag;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      sts_q   <= '0;
    end else begin
      sts_q.done <= 1'b0;
      case (state_q)
        N_IDLE: begin
          if (start_i) begin
            for (int i = 0; i < 3; i++) begin
              mag_q[i] <= mag_in[i];
              neg_q[i] <= vec_i[i][63];
            end
            if ((mag_in[0] | mag_in[1] | mag_in[2]) == 64'd0) begin
              sts_q.done <= 1'b1;
              sts_q.zero <= 1'b1;
            end else begin
              state_q <= N_SHIFT;
            end
          end
        end
        // bring the largest magnitude into [2^30, 2^31)
        N_SHIFT: begin
          if (orv[63:31] != '0) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          end else if (orv[63:30] == '0) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
          end else begin
            sum_q   <= 64'd0;
            idx_q   <= 2'd0;
            state_q <= N_SQ;
          end
        end
        N_SQ: begin
          if (idx_q == 2'd2) begin
            rn_q    <= sum_q + 64'(sq);
            res_q   <= 64'd0;
            bit_q   <= 64'd1 << 62;
            state_q <= N_SQRT;
          end else begin
            sum_q <= sum_q + 64'(sq);
            idx_q <= idx_q + 2'd1;
          end
        end
        // one result bit per cycle
        N_SQRT: begin
          if (take) begin
            rn_q  <= rn_q - trial[63:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            len_q   <= take ? 32'((res_q >> 1) + bit_q) : 32'(res_q >> 1);
            idx_q   <= 2'd0;
            state_q <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          num_q   <= NUM_W'({mag_q[idx_q][30:0], {FRAC_BITS{1'b0}}}) +
                     NUM_W'(len_q[31:1]);
          rem_q   <= 32'd0;
          quo_q   <= '0;
          dcnt_q  <= '0;
          state_q <= N_DIV;
        end
        // restoring division, one quotient bit per cycle
        N_DIV: begin
          rem_q  <= rem_nx;
          quo_q  <= quo_nx;
          num_q  <= num_q << 1;
          dcnt_q <= dcnt_q + DCNT_W'(1);
          if (dcnt_q == DCNT_W'(NUM_W - 1)) begin
            out_q[idx_q] <= qval;
            if (idx_q == 2'd2) begin
              sts_q.done <= 1'b1;
              sts_q.zero <= 1'b0;
              state_q    <= N_IDLE;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= N_DLOAD;
            end
          end
        end
        default: begin
          state_q <= N_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/lav_core.sv */
`default_nettype none
// ============================================================================
// lav_core: back end sequencer
// Builds the basis through the normalizer, forms cross and dot products on
// one shared multiplier and sends the four matrix rows.
// ============================================================================
module lav_core import lav_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        avail_i,
  input  wire item_t       item_i,
  output logic             pop_o,
  input  wire word_t [2:0] up_i,
  output logic             nstart_o,
  output wide_t [2:0]      nvec_o,
  input  wire norm_sts_t   nsts_i,
  input  wire basis_t [2:0] nbas_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  typedef enum logic [2:0] {
    C_IDLE, C_WZ, C_CR1, C_WX, C_CR2, C_WY, C_DOT, C_EMIT
  } state_e;

  localparam wide_t SAT_MAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam wide_t SAT_MIN = -SAT_MAX - 64'sd1;
  localparam wide_t RND     = 64'sd1 <<< (FRAC_BITS - 1);

  state_e             state_q;
  word_t [2:0]        eye_q;
  wide_t [2:0]        nvec_q;
  logic               nstart_q;
  basis_t [2:0][2:0]  bas_q;
  word_t [2:0]        t_q;
  wide_t              acc_q;
  logic [2:0]         step_q;
  logic [1:0]         r_q;
  logic [1:0]         c_q;
  logic               degen_q;
  logic               res_valid_q;
  res_t               res_q;

  logic [1:0]         cc;
  logic               sec;
  logic [1:0]         ia;
  logic [1:0]         ib;
  word_t              mul_a;
  basis_t             mul_b;
  logic signed [PROD_W-1:0] prod;
  wide_t              prod64;
  wide_t              tot;
  wide_t              shf;
  wide_t              ng;
  word_t              tsat;

  function automatic logic [1:0] inc3(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  assign pop_o       = (state_q == C_IDLE) && avail_i;
  assign nstart_o    = nstart_q;
  assign nvec_o      = nvec_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Cross product term select: component cc, second term subtracts
  assign cc  = step_q[2:1];
  assign sec = step_q[0];
  assign ia  = sec ? inc3(inc3(cc)) : inc3(cc);
  assign ib  = sec ? inc3(cc) : inc3(inc3(cc));

  // Shared multiplier operands
  always_comb begin
    case (state_q)
      C_CR1: begin
        mul_a = up_i[ia];
        mul_b = bas_q[2][ib];
      end
      C_CR2: begin
        mul_a = {{(32 - BAS_W){bas_q[2][ia][BAS_W-1]}}, bas_q[2][ia]};
        mul_b = bas_q[0][ib];
      end
      C_DOT: begin
        mul_a = eye_q[c_q];
        mul_b = bas_q[r_q][c_q];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Product, dot total, rounding and saturation of the translation
  always_comb begin
    prod   = mul_a * mul_b;
    prod64 = wide_t'(prod);
    tot    = acc_q + prod64;
    shf    = (tot + RND) >>> FRAC_BITS;
    ng     = -shf;
    if (ng > SAT_MAX) begin
      tsat = word_t'(SAT_MAX);
    end else if (ng < SAT_MIN) begin
      tsat = word_t'(SAT_MIN);
    end else begin
      tsat = ng[31:0];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_IDLE;
      nstart_q    <= 1'b0;
      res_valid_q <= 1'b0;
      degen_q     <= 1'b0;
    end else begin
      nstart_q    <= 1'b0;
      res_valid_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (avail_i) begin
            eye_q <= item_i.eye;
            for (int i = 0; i < 3; i++) begin
              nvec_q[i] <= -wide_t'($signed(item_i.dir[i]));
            end
            nstart_q <= 1'b1;
            degen_q  <= 1'b0;
            state_q  <= C_WZ;
          end
        end
        C_WZ: begin
          if (nsts_i.done) begin
            if (nsts_i.zero) begin
              degen_q <= 1'b1;
              r_q     <= 2'd0;
              state_q <= C_EMIT;
            end else begin
              bas_q[2] <= nbas_i;
              step_q   <= 3'd0;
              state_q  <= C_CR1;
            end
          end
        end
        // up cross z, one term per cycle
        C_CR1: begin
          nvec_q[cc] <= sec ? (nvec_q[cc] - prod64) : prod64;
          if (step_q == 3'd5) begin
            nstart_q <= 1'b1;
            state_q  <= C_WX;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        C_WX: begin
          if (nsts_i.done) begin
            if (nsts_i.zero) begin
              degen_q <= 1'b1;
              r_q     <= 2'd0;
              state_q <= C_EMIT;
            end else begin
              bas_q[0] <= nbas_i;
              step_q   <= 3'd0;
              state_q  <= C_CR2;
            end
          end
        end
        // z cross x
        C_CR2: begin
          nvec_q[cc] <= sec ? (nvec_q[cc] - prod64) : prod64;
          if (step_q == 3'd5) begin
            nstart_q <= 1'b1;
            state_q  <= C_WY;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        C_WY: begin
          if (nsts_i.done) begin
            if (nsts_i.zero) begin
              degen_q <= 1'b1;
              r_q     <= 2'd0;
              state_q <= C_EMIT;
            end else begin
              bas_q[1] <= nbas_i;
              r_q      <= 2'd0;
              c_q      <= 2'd0;
              state_q  <= C_DOT;
            end
          end
        end
        // basis row dot eye, one term per cycle
        C_DOT: begin
          if (c_q == 2'd0) begin
            acc_q <= prod64;
            c_q   <= 2'd1;
          end else if (c_q == 2'd1) begin
            acc_q <= tot;
            c_q   <= 2'd2;
          end else begin
            t_q[r_q] <= tsat;
            c_q      <= 2'd0;
            if (r_q == 2'd2) begin
              r_q     <= 2'd0;
              state_q <= C_EMIT;
            end else begin
              r_q <= r_q + 2'd1;
            end
          end
        end
        // one row beat per cycle
        C_EMIT: begin
          res_valid_q          <= 1'b1;
          res_q.row_index      <= r_q;
          res_q.last_row       <= (r_q == 2'd3);
          res_q.degenerate     <= degen_q;
          if (degen_q) begin
            res_q.col0 <= '0;
            res_q.col1 <= '0;
            res_q.col2 <= '0;
            res_q.col3 <= '0;
          end else if (r_q == 2'd3) begin
            res_q.col0 <= '0;
            res_q.col1 <= '0;
            res_q.col2 <= '0;
            res_q.col3 <= ONE;
          end else begin
            res_q.col0 <= word_t'(bas_q[r_q][0]);
            res_q.col1 <= word_t'(bas_q[r_q][1]);
            res_q.col2 <= word_t'(bas_q[r_q][2]);
            res_q.col3 <= t_q[r_q];
          end
          if (r_q == 2'd3) begin
            state_q <= C_IDLE;
          end else begin
            r_q <= r_q + 2'd1;
          end
        end
        default: begin
          state_q <= C_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/look_at_view_matrix.sv */
`default_nettype none
// ============================================================================
// look_at_view_matrix: fixed-point camera view matrix
// Camera eye and direction in, four view matrix rows out.
// ============================================================================
// Usage:
//   Command channel: a beat is taken at a rising edge with start_i high and
//   busy_o low. A two-entry queue holds commands while the back end works,
//   so up to two commands can wait behind the one in progress.
//   Config: cfg_we_i writes cfg_wdata_i into up_x, up_y or up_z by
//   cfg_idx_i; index 3 is ignored. Write only while the block is idle.
//   Results: four beats per command, rows 0 to 3, each shown for one cycle
//   with res_valid_o high; last_row_o marks row 3. The receiver cannot
//   stall, so no beat is ever held back or dropped.
//   Processing: each command takes three passes through the serial
//   normalizer, two cross products, three dot products and four row
//   beats. The back end takes the next command from the queue only after
//   the last row of the one before; its pace is set by the
//   one-bit-per-cycle square root and divider in the normalizer.
//   A zero-length vector cuts the command short and sends four zero rows
//   flagged degenerate.
//   Reset: queue empty, sequencers idle, up vector set to (0, 1.0, 0).
// ============================================================================
module look_at_view_matrix import lav_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic signed [31:0] eye_x_i,
  input  wire logic signed [31:0] eye_y_i,
  input  wire logic signed [31:0] eye_z_i,
  input  wire logic signed [31:0] dir_x_i,
  input  wire logic signed [31:0] dir_y_i,
  input  wire logic signed [31:0] dir_z_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  output logic             res_valid_o,
  output logic [1:0]       row_index_o,
  output logic signed [31:0] col0_o,
  output logic signed [31:0] col1_o,
  output logic signed [31:0] col2_o,
  output logic signed [31:0] col3_o,
  output logic             last_row_o,
  output logic             degenerate_o
);

  word_t [2:0]  up_q;
  item_t        cmd;
  item_t        q_item;
  logic         q_avail;
  logic         q_pop;
  logic         nstart;
  wide_t [2:0]  nvec;
  norm_sts_t    nsts;
  basis_t [2:0] nbas;
  res_t         res;

  // Up vector registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q[0] <= UP_X_RESET;
      up_q[1] <= UP_Y_RESET;
      up_q[2] <= UP_Z_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UP_X: up_q[0] <= cfg_wdata_i;
        CFG_UP_Y: up_q[1] <= cfg_wdata_i;
        CFG_UP_Z: up_q[2] <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Command beat packing
  assign cmd.eye[0] = eye_x_i;
  assign cmd.eye[1] = eye_y_i;
  assign cmd.eye[2] = eye_z_i;
  assign cmd.dir[0] = dir_x_i;
  assign cmd.dir[1] = dir_y_i;
  assign cmd.dir[2] = dir_z_i;

  lav_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (cmd),
    .busy_o  (busy_o),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .item_o  (q_item)
  );

  lav_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nstart),
    .vec_i   (nvec),
    .sts_o   (nsts),
    .vec_o   (nbas)
  );

  lav_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (q_avail),
    .item_i      (q_item),
    .pop_o       (q_pop),
    .up_i        (up_q),
    .nstart_o    (nstart),
    .nvec_o      (nvec),
    .nsts_i      (nsts),
    .nbas_i      (nbas),
    .res_valid_o (res_valid_o),
    .res_o       (res)
  );

  // Result beat unpacking
  assign row_index_o  = res.row_index;
  assign col0_o       = res.col0;
  assign col1_o       = res.col1;
  assign col2_o       = res.col2;
  assign col3_o       = res.col3;
  assign last_row_o   = res.last_row;
  assign degenerate_o = res.degenerate;

endmodule
`default_nettype wire
